FILE: hw/rtl/bpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier path follower package
// Shared types, register codes and sizing constants.
// ----------------------------------------------------------------------------
package bpf_pkg;

   localparam int MAX_SEGMENTS_DEF = 16;
   localparam int ELAPSED_W        = 17;
   localparam int ELAPSED_MAX      = 131071;
   localparam int COEF_W           = 21;
   localparam int POINT_W          = 48;
   localparam int ROT_W            = 50;
   localparam int MUL_A_W          = 35;
   localparam int MUL_B_W          = 18;
   localparam int PROD_W           = 53;
   localparam int FRAC_BITS        = 16;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      CSR_SEGMENT_COUNT = 3'd0,
      CSR_ROTATE_ON     = 3'd1,
      CSR_ROTATION_COS  = 3'd2,
      CSR_ROTATION_SIN  = 3'd3,
      CSR_OFFSET_X      = 3'd4,
      CSR_OFFSET_Y      = 3'd5
   } csr_addr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_FINAL,
      ST_EMIT
   } back_state_type;

   typedef enum logic [3:0] {
      OP_TT  = 4'd0,
      OP_T2T = 4'd1,
      OP_AX  = 4'd2,
      OP_BBX = 4'd3,
      OP_CX  = 4'd4,
      OP_AY  = 4'd5,
      OP_BBY = 4'd6,
      OP_CY  = 4'd7,
      OP_DXC = 4'd8,
      OP_DYS = 4'd9,
      OP_DXS = 4'd10,
      OP_DYC = 4'd11
   } op_type;

   typedef struct packed {
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] k1x;
      logic signed [15:0] k1y;
      logic signed [15:0] k2x;
      logic signed [15:0] k2y;
      logic signed [15:0] ex;
      logic signed [15:0] ey;
      logic [15:0]        dur;
   } seg_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] slot;
      seg_type    seg;
      logic [9:0] tick;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } front_out_type;

   typedef struct packed {
      logic [4:0]         segment_count;
      logic               rotate_on;
      logic signed [15:0] rot_cos;
      logic signed [15:0] rot_sin;
      logic signed [15:0] off_x;
      logic signed [15:0] off_y;
   } cfg_type;

endpackage

FILE: hw/rtl/bpf_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries load and tick items into the path follower.
// ----------------------------------------------------------------------------
interface bpf_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [3:0]         segment_slot;
   logic signed [15:0] begin_x;
   logic signed [15:0] begin_y;
   logic signed [15:0] ctrl1_x;
   logic signed [15:0] ctrl1_y;
   logic signed [15:0] ctrl2_x;
   logic signed [15:0] ctrl2_y;
   logic signed [15:0] finish_x;
   logic signed [15:0] finish_y;
   logic [15:0]        duration_ms;
   logic [9:0]         tick_ms;

   modport source (
      output valid, req_type, segment_slot, begin_x, begin_y, ctrl1_x, ctrl1_y,
             ctrl2_x, ctrl2_y, finish_x, finish_y, duration_ms, tick_ms,
      input  ready
   );
   modport sink (
      input  valid, req_type, segment_slot, begin_x, begin_y, ctrl1_x, ctrl1_y,
             ctrl2_x, ctrl2_y, finish_x, finish_y, duration_ms, tick_ms,
      output ready
   );
endinterface

FILE: hw/rtl/bpf_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Carries one position item per tick out of the path follower.
// ----------------------------------------------------------------------------
interface bpf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [4:0]         current_segment;
   logic               path_done;

   modport source (
      output valid, pos_x, pos_y, current_segment, path_done,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, current_segment, path_done,
      output ready
   );
endinterface

FILE: hw/rtl/bpf_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/bpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path follower front end
// Accepts request items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bpf_front (
   input  logic                    clock,
   input  logic                    reset,
   bpf_req_if.sink                 req_ch,
   input  logic                    pop,
   output bpf_pkg::front_out_type  front_out
);

   bpf_pkg::item_type fifo_ff [2];
   bpf_pkg::item_type item_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;
   logic              do_pop;

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push         = req_ch.valid & req_ch.ready;
   assign do_pop       = pop & (cnt_ff != 2'd0);

   always_comb begin
      item_in.kind     = bpf_pkg::kind_type'(req_ch.req_type);
      item_in.slot     = req_ch.segment_slot;
      item_in.seg.bx   = req_ch.begin_x;
      item_in.seg.by   = req_ch.begin_y;
      item_in.seg.k1x  = req_ch.ctrl1_x;
      item_in.seg.k1y  = req_ch.ctrl1_y;
      item_in.seg.k2x  = req_ch.ctrl2_x;
      item_in.seg.k2y  = req_ch.ctrl2_y;
      item_in.seg.ex   = req_ch.finish_x;
      item_in.seg.ey   = req_ch.finish_y;
      item_in.seg.dur  = req_ch.duration_ms;
      item_in.tick     = req_ch.tick_ms;
      wr_ptr_in        = wr_ptr_ff ^ push;
      rd_ptr_in        = rd_ptr_ff ^ do_pop;
      cnt_in           = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign front_out.valid = (cnt_ff != 2'd0);
   assign front_out.item  = fifo_ff[rd_ptr_ff];

endmodule

FILE: hw/rtl/bpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path follower back end
// Segment table, segment walk, serial divider and shared multiply sequencer.
// ----------------------------------------------------------------------------
module bpf_back #(
   parameter int MAX_SEGMENTS = bpf_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bpf_pkg::front_out_type front_out,
   output logic                   pop,
   input  bpf_pkg::cfg_type       cfg,
   bpf_rsp_if.source              rsp_ch
);

   localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int IDX_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int CNT_W  = (IDX_W > 5) ? IDX_W : 5;
   localparam int EW     = bpf_pkg::ELAPSED_W;
   localparam int CW     = bpf_pkg::COEF_W;
   localparam int PW     = bpf_pkg::POINT_W;
   localparam int RW     = bpf_pkg::ROT_W;

   bpf_pkg::back_state_type state_ff, state_in;

   bpf_pkg::seg_type seg_mem [MAX_SEGMENTS];
   bpf_pkg::seg_type rd_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;

   logic [EW-1:0]     elapsed_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic signed [15:0] b0x_ff, b0y_ff;
   logic [EW-1:0]     rem_ff;
   logic [EW-1:0]     tq_ff;
   logic [4:0]        bitcnt_ff;
   logic [EW-1:0]     t2_ff, t3_ff;
   logic signed [CW-1:0] ax_ff, bbx_ff, cx_ff, ay_ff, bby_ff, cy_ff;
   bpf_pkg::op_type   step_ff;
   logic signed [bpf_pkg::PROD_W-1:0] prod_ff;
   logic signed [PW-1:0] accx_ff, accy_ff;
   logic signed [RW-1:0] rx_ff, ry_ff;
   logic signed [RW-1:0] basex_ff, basey_ff;
   logic              done_ff;
   logic              out_valid_ff;
   logic signed [15:0] out_x_ff, out_y_ff;
   logic [4:0]        out_seg_ff;
   logic              out_done_ff;

   logic [CNT_W-1:0]  count_eff;
   logic              at_end;
   logic              is_load, is_tick;
   logic              slot_ok;
   logic [EW:0]       elapsed_sum;
   logic              skip;
   logic              last_op;
   logic              emit_fire;
   logic [EW:0]       rem_dbl;
   logic              div_ge;
   logic              q0;

   logic signed [CW-1:0] cx_w, bbx_w, ax_w, cy_w, bby_w, ay_w;
   logic signed [bpf_pkg::MUL_A_W-1:0] mul_a, dx_w, dy_w;
   logic signed [bpf_pkg::MUL_B_W-1:0] mul_b;
   logic signed [PW-1:0] b0x_w, b0y_w, bx_w, by_w, prod_p;
   logic signed [RW-1:0] prod_r, rotx_w, roty_w, sumx_w, sumy_w, shx_w, shy_w;

   // Effective segment count, clamped to the table size.
   assign count_eff = (int'(cfg.segment_count) > MAX_SEGMENTS) ?
                      CNT_W'(MAX_SEGMENTS) : CNT_W'(cfg.segment_count);
   assign at_end    = (CNT_W'(idx_ff) >= count_eff);
   assign is_load   = front_out.valid & (front_out.item.kind == bpf_pkg::KIND_LOAD);
   assign is_tick   = front_out.valid & (front_out.item.kind == bpf_pkg::KIND_TICK);
   assign slot_ok   = (int'(front_out.item.slot) < MAX_SEGMENTS);
   assign elapsed_sum = {1'b0, elapsed_ff} + (EW+1)'(front_out.item.tick);
   assign skip      = (elapsed_ff > EW'(rd_ff.dur));
   assign last_op   = cfg.rotate_on ? (step_ff == bpf_pkg::OP_DYC) :
                                      (step_ff == bpf_pkg::OP_CY);
   assign emit_fire = (state_ff == bpf_pkg::ST_EMIT) & (~out_valid_ff | rsp_ch.ready);
   assign rem_dbl   = {rem_ff, 1'b0};
   assign div_ge    = (rem_dbl >= (EW+1)'(rd_ff.dur));
   assign q0        = (rd_ff.dur != 16'd0) & (elapsed_ff >= EW'(rd_ff.dur));
   assign rd_addr   = idx_ff[ADDR_W-1:0];
   assign mem_we    = (state_ff == bpf_pkg::ST_IDLE) & is_load & slot_ok;

   // Power-basis coefficients of the current segment.
   always_comb begin
      cx_w  = CW'(3) * (CW'(rd_ff.k1x) - CW'(rd_ff.bx));
      bbx_w = CW'(3) * (CW'(rd_ff.k2x) - CW'(rd_ff.k1x)) - cx_w;
      ax_w  = CW'(rd_ff.ex) - CW'(rd_ff.bx) - cx_w - bbx_w;
      cy_w  = CW'(3) * (CW'(rd_ff.k1y) - CW'(rd_ff.by));
      bby_w = CW'(3) * (CW'(rd_ff.k2y) - CW'(rd_ff.k1y)) - cy_w;
      ay_w  = CW'(rd_ff.ey) - CW'(rd_ff.by) - cy_w - bby_w;
   end

   assign b0x_w  = {{16{b0x_ff[15]}}, b0x_ff, 16'h0000};
   assign b0y_w  = {{16{b0y_ff[15]}}, b0y_ff, 16'h0000};
   assign bx_w   = {{16{rd_ff.bx[15]}}, rd_ff.bx, 16'h0000};
   assign by_w   = {{16{rd_ff.by[15]}}, rd_ff.by, 16'h0000};
   assign dx_w   = bpf_pkg::MUL_A_W'(accx_ff - b0x_w);
   assign dy_w   = bpf_pkg::MUL_A_W'(accy_ff - b0y_w);
   assign prod_p = PW'(prod_ff);
   assign prod_r = RW'(prod_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      case (step_ff)
         bpf_pkg::OP_TT: begin
            mul_a = bpf_pkg::MUL_A_W'(tq_ff);
            mul_b = bpf_pkg::MUL_B_W'(tq_ff);
         end
         bpf_pkg::OP_T2T: begin
            mul_a = bpf_pkg::MUL_A_W'(t2_ff);
            mul_b = bpf_pkg::MUL_B_W'(tq_ff);
         end
         bpf_pkg::OP_AX: begin
            mul_a = bpf_pkg::MUL_A_W'(ax_ff);
            mul_b = bpf_pkg::MUL_B_W'(t3_ff);
         end
         bpf_pkg::OP_BBX: begin
            mul_a = bpf_pkg::MUL_A_W'(bbx_ff);
            mul_b = bpf_pkg::MUL_B_W'(t2_ff);
         end
         bpf_pkg::OP_CX: begin
            mul_a = bpf_pkg::MUL_A_W'(cx_ff);
            mul_b = bpf_pkg::MUL_B_W'(tq_ff);
         end
         bpf_pkg::OP_AY: begin
            mul_a = bpf_pkg::MUL_A_W'(ay_ff);
            mul_b = bpf_pkg::MUL_B_W'(t3_ff);
         end
         bpf_pkg::OP_BBY: begin
            mul_a = bpf_pkg::MUL_A_W'(bby_ff);
            mul_b = bpf_pkg::MUL_B_W'(t2_ff);
         end
         bpf_pkg::OP_CY: begin
            mul_a = bpf_pkg::MUL_A_W'(cy_ff);
            mul_b = bpf_pkg::MUL_B_W'(tq_ff);
         end
         bpf_pkg::OP_DXC: begin
            mul_a = dx_w;
            mul_b = bpf_pkg::MUL_B_W'(cfg.rot_cos);
         end
         bpf_pkg::OP_DYS: begin
            mul_a = dy_w;
            mul_b = bpf_pkg::MUL_B_W'(cfg.rot_sin);
         end
         bpf_pkg::OP_DXS: begin
            mul_a = dx_w;
            mul_b = bpf_pkg::MUL_B_W'(cfg.rot_sin);
         end
         bpf_pkg::OP_DYC: begin
            mul_a = dy_w;
            mul_b = bpf_pkg::MUL_B_W'(cfg.rot_cos);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Final rotation rounding and offset.
   always_comb begin
      rotx_w = ((rx_ff + RW'(8192)) >>> 14) + RW'(b0x_w);
      roty_w = ((ry_ff + RW'(8192)) >>> 14) + RW'(b0y_w);
      sumx_w = basex_ff + {{18{cfg.off_x[15]}}, cfg.off_x, 16'h0000} + RW'(32768);
      sumy_w = basey_ff + {{18{cfg.off_y[15]}}, cfg.off_y, 16'h0000} + RW'(32768);
      shx_w  = sumx_w >>> bpf_pkg::FRAC_BITS;
      shy_w  = sumy_w >>> bpf_pkg::FRAC_BITS;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      case (state_ff)
         bpf_pkg::ST_IDLE: begin
            pop = front_out.valid;
            if (is_tick) begin
               state_in = bpf_pkg::ST_READ;
            end
         end
         bpf_pkg::ST_READ: begin
            state_in = at_end ? bpf_pkg::ST_EMIT : bpf_pkg::ST_CHECK;
         end
         bpf_pkg::ST_CHECK: begin
            if (skip) begin
               state_in = bpf_pkg::ST_READ;
            end else if (rd_ff.dur == 16'd0) begin
               state_in = bpf_pkg::ST_MUL;
            end else begin
               state_in = bpf_pkg::ST_DIV;
            end
         end
         bpf_pkg::ST_DIV: begin
            if (bitcnt_ff == 5'd1) begin
               state_in = bpf_pkg::ST_MUL;
            end
         end
         bpf_pkg::ST_MUL: begin
            state_in = bpf_pkg::ST_ACC;
         end
         bpf_pkg::ST_ACC: begin
            state_in = last_op ? bpf_pkg::ST_FINAL : bpf_pkg::ST_MUL;
         end
         bpf_pkg::ST_FINAL: begin
            state_in = bpf_pkg::ST_EMIT;
         end
         bpf_pkg::ST_EMIT: begin
            if (emit_fire) begin
               state_in = bpf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Segment table with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem[ADDR_W'(front_out.item.slot)] <= front_out.item.seg;
      end
      rd_ff <= seg_mem[rd_addr];
   end

   // Walk state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == bpf_pkg::ST_IDLE) begin
            if (is_load) begin
               elapsed_ff <= '0;
               idx_ff     <= '0;
            end else if (is_tick) begin
               elapsed_ff <= elapsed_sum[EW] ? EW'(bpf_pkg::ELAPSED_MAX) : elapsed_sum[EW-1:0];
            end
         end else if ((state_ff == bpf_pkg::ST_CHECK) && skip) begin
            elapsed_ff <= elapsed_ff - EW'(rd_ff.dur);
            idx_ff     <= idx_ff + IDX_W'(1);
         end
         if (rsp_ch.valid & rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (emit_fire) begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   // Arithmetic datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         bpf_pkg::ST_IDLE: begin
            done_ff <= 1'b0;
            if (is_load && (front_out.item.slot == 4'd0) && slot_ok) begin
               b0x_ff <= front_out.item.seg.bx;
               b0y_ff <= front_out.item.seg.by;
            end
         end
         bpf_pkg::ST_READ: begin
            done_ff <= at_end;
         end
         bpf_pkg::ST_CHECK: begin
            rem_ff    <= q0 ? (elapsed_ff - EW'(rd_ff.dur)) : elapsed_ff;
            tq_ff     <= EW'(q0);
            bitcnt_ff <= 5'd16;
            step_ff   <= bpf_pkg::OP_TT;
            ax_ff     <= ax_w;
            bbx_ff    <= bbx_w;
            cx_ff     <= cx_w;
            ay_ff     <= ay_w;
            bby_ff    <= bby_w;
            cy_ff     <= cy_w;
         end
         bpf_pkg::ST_DIV: begin
            // One quotient bit per cycle, restoring form.
            rem_ff    <= div_ge ? EW'(rem_dbl - (EW+1)'(rd_ff.dur)) : rem_dbl[EW-1:0];
            tq_ff     <= {tq_ff[EW-2:0], div_ge};
            bitcnt_ff <= bitcnt_ff - 5'd1;
         end
         bpf_pkg::ST_MUL: begin
            prod_ff <= mul_a * mul_b;
         end
         bpf_pkg::ST_ACC: begin
            case (step_ff)
               bpf_pkg::OP_TT:  t2_ff <= EW'((prod_ff + 53'sd32768) >>> 16);
               bpf_pkg::OP_T2T: t3_ff <= EW'((prod_ff + 53'sd32768) >>> 16);
               bpf_pkg::OP_AX:  accx_ff <= bx_w + prod_p;
               bpf_pkg::OP_BBX: accx_ff <= accx_ff + prod_p;
               bpf_pkg::OP_CX:  accx_ff <= accx_ff + prod_p;
               bpf_pkg::OP_AY:  accy_ff <= by_w + prod_p;
               bpf_pkg::OP_BBY: accy_ff <= accy_ff + prod_p;
               bpf_pkg::OP_CY:  accy_ff <= accy_ff + prod_p;
               bpf_pkg::OP_DXC: rx_ff <= prod_r;
               bpf_pkg::OP_DYS: rx_ff <= rx_ff - prod_r;
               bpf_pkg::OP_DXS: ry_ff <= prod_r;
               bpf_pkg::OP_DYC: ry_ff <= ry_ff + prod_r;
               default: ;
            endcase
            step_ff <= bpf_pkg::op_type'(4'(step_ff) + 4'd1);
         end
         bpf_pkg::ST_FINAL: begin
            basex_ff <= cfg.rotate_on ? rotx_w : RW'(accx_ff);
            basey_ff <= cfg.rotate_on ? roty_w : RW'(accy_ff);
         end
         bpf_pkg::ST_EMIT: begin
            if (emit_fire) begin
               out_seg_ff  <= 5'(idx_ff);
               out_done_ff <= done_ff;
               if (done_ff) begin
                  out_x_ff <= '0;
                  out_y_ff <= '0;
               end else begin
                  out_x_ff <= (shx_w > RW'(32767)) ? 16'sh7fff :
                              (shx_w < -RW'(32768)) ? 16'sh8000 : shx_w[15:0];
                  out_y_ff <= (shy_w > RW'(32767)) ? 16'sh7fff :
                              (shy_w < -RW'(32768)) ? 16'sh8000 : shy_w[15:0];
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.pos_x           = out_x_ff;
   assign rsp_ch.pos_y           = out_y_ff;
   assign rsp_ch.current_segment = out_seg_ff;
   assign rsp_ch.path_done       = out_done_ff;

endmodule

FILE: hw/rtl/bezier_path_follower.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier path follower
// Follows a timed path of cubic Bezier segments and reports one position per
// tick item.
// ----------------------------------------------------------------------------
// A load item is handled in the back end without the divider or multiplier; a tick
// item walks past skipped segments, then runs the serial divider for t (skipped on a
// zero duration) and the shared multiplier for 8 (or 12 with rotation on) products;
// when the path is done it goes straight to the output. After a tick item the back end
// takes no new item until its position is emitted; the front end queues up to two.
// Reset is synchronous and active high; the segment table is not cleared.
// ----------------------------------------------------------------------------
module bezier_path_follower #(
   parameter int MAX_SEGMENTS = bpf_pkg::MAX_SEGMENTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bpf_req_if.sink    req_ch,
   bpf_rsp_if.source  rsp_ch,
   bpf_csr_if.sink    csr_ch
);

   // Configuration registers. Writes must arrive only while the block is idle; the
   // block itself does not enforce this, and the back end reads them directly.
   bpf_pkg::cfg_type       cfg_ff;
   bpf_pkg::front_out_type front_out;
   logic                   pop;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.segment_count <= 5'd0;
         cfg_ff.rotate_on     <= 1'b0;
         cfg_ff.rot_cos       <= 16'sd16384;
         cfg_ff.rot_sin       <= 16'sd0;
         cfg_ff.off_x         <= 16'sd0;
         cfg_ff.off_y         <= 16'sd0;
      end else if (csr_ch.valid) begin
         case (bpf_pkg::csr_addr_type'(csr_ch.index))
            bpf_pkg::CSR_SEGMENT_COUNT: cfg_ff.segment_count <= csr_ch.data[4:0];
            bpf_pkg::CSR_ROTATE_ON:     cfg_ff.rotate_on     <= csr_ch.data[0];
            bpf_pkg::CSR_ROTATION_COS:  cfg_ff.rot_cos       <= csr_ch.data;
            bpf_pkg::CSR_ROTATION_SIN:  cfg_ff.rot_sin       <= csr_ch.data;
            bpf_pkg::CSR_OFFSET_X:      cfg_ff.off_x         <= csr_ch.data;
            bpf_pkg::CSR_OFFSET_Y:      cfg_ff.off_y         <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // The front end queues and classifies items so that the request side can
   // keep moving while the back end walks, divides and multiplies.
   bpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .pop       (pop),
      .front_out (front_out)
   );

   // The back end owns the segment table and the walk state; its output
   // register holds a finished item until the response side takes it.
   bpf_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .front_out (front_out),
      .pop       (pop),
      .cfg       (cfg_ff),
      .rsp_ch    (rsp_ch)
   );

endmodule
